// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files of the morphology window filter.
// Depends on nothing; synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MWF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define MWF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define MWF_ASSERT(lbl, clk, rst_n, prop)
`define MWF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/mwf_pkg.sv =====
// Shared types, constants and helper functions of the morphology window filter.
// Depends on nothing; mwf_cell and the top level import it.
package mwf_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int KSIZE_W    = 3;
    localparam int MASK_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_IMAGE_HEIGHT  = 3'd2,
        CFG_KERNEL_HEIGHT = 3'd3,
        CFG_KERNEL_WIDTH  = 3'd4,
        CFG_ELEMENT_MASK  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             flush;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last;
    } out_item_t;

    // Element bit for row a, column b of the structuring element (stride five).
    function automatic logic mask_at(input logic [MASK_W-1:0] mask,
                                     input logic [2:0] a, input logic [2:0] b);
        logic [4:0] idx;
        idx = 5'(a) * 5'd5 + 5'(b);
        return mask[idx];
    endfunction

endpackage

// ===== design/mwf_ram.sv =====
// Generic simple dual-port RAM with registered read, used for the line buffers.
// Depends on nothing.
module mwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/mwf_cell.sv =====
// One window cell: holds a pixel, takes its left neighbor's pixel on a shift,
// and offers its masked term for the max and all-ones reductions. Uses mwf_pkg.
module mwf_cell (
    input  logic                    aclk,
    input  logic                    shift_en,
    input  logic [mwf_pkg::PIX_W-1:0] pix_in,
    input  logic                    term_en,
    output logic [mwf_pkg::PIX_W-1:0] pix_out,
    output logic [mwf_pkg::PIX_W-1:0] max_term,
    output logic                    ones_term
);
    import mwf_pkg::*;

    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    assign pix_out   = pix_reg;
    assign max_term  = term_en ? pix_reg : PIX_ZERO;
    assign ones_term = !term_en || (pix_reg == PIX_MAX);
endmodule

// ===== design/morphology_window_filter.sv =====
// Morphology window filter top level: line buffers, a chain of window cells
// and the reduction pipeline. Uses mwf_pkg, mwf_ram, mwf_cell, assert_macros.svh.
//
// Usage. Pixels enter in raster order on the s_ channel (s_valid, s_ready,
// s_data). After the last pixel of a frame the sender adds flush items until
// the result marked last has come out; a flush item that arrives while the
// frame still has pixels to come is taken and dropped. Results leave on the
// m_ channel (m_valid, m_ready, m_data). Result n belongs to the transfer of
// frame position n + (kernel_height/2)*image_width + kernel_width/2.
// The result reaches m_data through the stage B registers, the window cells,
// the stage D registers and the output register. Throughput: one item per cycle
// while s_ready is high; every stage, including the line buffer RAM ports, handles one item a clock.
// The cfg_ channel writes one register per transfer and restarts the frame
// when the index is known; s_ready is low in the cycle after each write, while sizes refresh.
// Reset puts the registers at their defaults and the frame at its start.
// The line buffers need no clearing pass: window positions outside the frame
// are masked, so only pixels of the current frame are ever used.
// When the receiver stalls, the output register holds the result and a skid
// register takes one more; only when the skid register is occupied does the
// whole pipeline freeze; s_ready then falls as well.
`include "assert_macros.svh"
module morphology_window_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mwf_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mwf_pkg::out_item_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mwf_pkg::*;

    // Largest usable kernel side, window side (even kernels lag one extra row
    // and column) and counter widths.
    localparam int KMAX  = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;
    localparam int NW    = 2 * (KMAX / 2) + 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WE_W  = COL_W + 1;
    localparam int POS_W = COL_W + DIM_W + 1;

    // Configuration registers.
    logic              mode_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [KSIZE_W-1:0] kh_reg, kw_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              settle_reg;

    logic [WE_W-1:0]    w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [KSIZE_W-1:0] kh_eff, kw_eff, khh, kwh;
    logic [POS_W-1:0]   total_reg, delay_reg;

    logic cfg_fire, cfg_known;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == CFG_MODE) || (cfg_index == CFG_IMAGE_WIDTH) ||
                       (cfg_index == CFG_IMAGE_HEIGHT) || (cfg_index == CFG_KERNEL_HEIGHT) ||
                       (cfg_index == CFG_KERNEL_WIDTH) || (cfg_index == CFG_ELEMENT_MASK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            kh_reg     <= 3'd3;
            kw_reg     <= 3'd3;
            mask_reg   <= '1;
            settle_reg <= 1'b1;
        end else begin
            settle_reg <= cfg_fire;
            if (cfg_fire) begin
                unique case (cfg_index)
                    CFG_MODE:          mode_reg   <= cfg_data[0];
                    CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[DIM_W-1:0];
                    CFG_KERNEL_HEIGHT: kh_reg     <= cfg_data[KSIZE_W-1:0];
                    CFG_KERNEL_WIDTH:  kw_reg     <= cfg_data[KSIZE_W-1:0];
                    CFG_ELEMENT_MASK:  mask_reg   <= cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Effective sizes: zero acts as one; an oversize width or kernel side is clamped.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WE_W'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_eff = WE_W'(MAX_WIDTH);
        end else begin
            w_eff = WE_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;
        if (kh_reg == '0) begin
            kh_eff = 3'd1;
        end else if (int'(kh_reg) > KMAX) begin
            kh_eff = 3'(KMAX);
        end else begin
            kh_eff = kh_reg;
        end
        if (kw_reg == '0) begin
            kw_eff = 3'd1;
        end else if (int'(kw_reg) > KMAX) begin
            kw_eff = 3'(KMAX);
        end else begin
            kw_eff = kw_reg;
        end
        khh = kh_eff >> 1;
        kwh = kw_eff >> 1;
    end

    // Frame size and trigger delay are refreshed every cycle; they only move
    // after a configuration write, and intake waits for them through settle_reg.
    always_ff @(posedge aclk) begin
        total_reg <= POS_W'(w_eff) * POS_W'(h_eff);
        delay_reg <= POS_W'(khh) * POS_W'(w_eff) + POS_W'(kwh);
    end

    // Stage A: intake and frame position counters.
    logic              en;
    logic              skid_valid_reg;
    logic              accept, in_frame, take, emit_a, last_a;
    logic [POS_W-1:0]  pos_reg;
    logic [COL_W-1:0]  in_col_reg, o_col_reg;
    logic [DIM_W-1:0]  o_row_reg;

    assign en       = !skid_valid_reg;
    assign s_ready  = en && !settle_reg;
    assign accept   = s_valid && s_ready;
    assign in_frame = pos_reg < total_reg;
    assign take     = accept && !(in_frame && s_data.flush);
    assign emit_a   = pos_reg >= delay_reg;
    assign last_a   = (o_row_reg == h_eff - DIM_W'(1)) &&
                      (WE_W'(o_col_reg) == w_eff - WE_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            in_col_reg <= '0;
            o_col_reg  <= '0;
            o_row_reg  <= '0;
        end else if (cfg_fire && cfg_known) begin
            pos_reg    <= '0;
            in_col_reg <= '0;
            o_col_reg  <= '0;
            o_row_reg  <= '0;
        end else if (take) begin
            if (emit_a && last_a) begin
                pos_reg    <= '0;
                in_col_reg <= '0;
                o_col_reg  <= '0;
                o_row_reg  <= '0;
            end else begin
                pos_reg <= pos_reg + POS_W'(1);
                if (WE_W'(in_col_reg) + WE_W'(1) >= w_eff) begin
                    in_col_reg <= '0;
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
                if (emit_a) begin
                    if (WE_W'(o_col_reg) + WE_W'(1) >= w_eff) begin
                        o_col_reg <= '0;
                        o_row_reg <= o_row_reg + DIM_W'(1);
                    end else begin
                        o_col_reg <= o_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // Stage B registers: item handed to the line buffers and the window.
    logic              b_valid_reg, b_emit_reg, b_last_reg, byp_reg;
    logic [PIX_W-1:0]  b_pix_reg;
    logic [COL_W-1:0]  b_col_reg, b_ocol_reg;
    logic [DIM_W-1:0]  b_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_pix_reg  <= s_data.pixel_in;
            b_col_reg  <= in_col_reg;
            b_emit_reg <= emit_a;
            b_last_reg <= last_a;
            b_row_reg  <= o_row_reg;
            b_ocol_reg <= o_col_reg;
        end
        // A read that meets the write of the same column gets the written data.
        if (take) begin
            byp_reg <= b_valid_reg && (b_col_reg == in_col_reg);
        end
    end

    logic             b_adv;
    logic [PIX_W-1:0] tap [NW];
    assign b_adv  = en && b_valid_reg;
    assign tap[0] = b_pix_reg;

    // Line buffer chain: buffer L delays the stream by exactly one row.
    for (genvar gl = 1; gl < NW; gl++) begin : g_line
        logic [PIX_W-1:0] rdata;
        logic [PIX_W-1:0] wbuf_reg;

        mwf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .aclk  (aclk),
            .we    (b_adv),
            .waddr (b_col_reg),
            .wdata (tap[gl-1]),
            .re    (take),
            .raddr (in_col_reg),
            .rdata (rdata)
        );

        always_ff @(posedge aclk) begin
            if (b_adv) begin
                wbuf_reg <= tap[gl-1];
            end
        end

        assign tap[gl] = byp_reg ? wbuf_reg : rdata;
    end

    // Cell enables for the window the item in stage B will see. Cell (L, M)
    // lags the newest pixel by L rows and M columns; it maps to element row
    // 2*(kh/2)-L and column 2*(kw/2)-M.
    logic             row_ok [NW];
    logic             col_ok [NW];
    logic [2:0]       a_idx  [NW];
    logic [2:0]       b_idx  [NW];
    logic [DIM_W:0]   rp;
    logic [WE_W-1:0]  cp;
    logic             en_next [NW][NW];

    always_comb begin
        rp = (DIM_W+1)'(b_row_reg) + (DIM_W+1)'(khh);
        cp = WE_W'(b_ocol_reg) + WE_W'(kwh);
        for (int l = 0; l < NW; l++) begin
            a_idx[l]  = {khh[1:0], 1'b0} - 3'(l);
            row_ok[l] = (3'(l) >= {2'b00, ~kh_eff[0]}) && (3'(l) <= {khh[1:0], 1'b0}) &&
                        (rp >= (DIM_W+1)'(l)) &&
                        ((rp - (DIM_W+1)'(l)) < (DIM_W+1)'(h_eff));
            b_idx[l]  = {kwh[1:0], 1'b0} - 3'(l);
            col_ok[l] = (3'(l) >= {2'b00, ~kw_eff[0]}) && (3'(l) <= {kwh[1:0], 1'b0}) &&
                        (cp >= WE_W'(l)) && ((cp - WE_W'(l)) < w_eff);
        end
        for (int l = 0; l < NW; l++) begin
            for (int m = 0; m < NW; m++) begin
                en_next[l][m] = row_ok[l] && col_ok[m] && mask_at(mask_reg, a_idx[l], b_idx[m]);
            end
        end
    end

    // Stage C registers.
    logic c_valid_reg, c_emit_reg, c_last_reg;
    logic c_en_reg [NW][NW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_emit_reg <= b_emit_reg;
            c_last_reg <= b_last_reg;
            c_en_reg   <= en_next;
        end
    end

    // Window: a row of cells per line tap, shifting one column per item.
    logic [PIX_W-1:0] win   [NW][NW];
    logic [PIX_W-1:0] cmax  [NW][NW];
    logic             cones [NW][NW];

    for (genvar gr = 0; gr < NW; gr++) begin : g_row
        for (genvar gc = 0; gc < NW; gc++) begin : g_col
            logic [PIX_W-1:0] feed;
            if (gc == 0) begin : g_head
                assign feed = tap[gr];
            end else begin : g_link
                assign feed = win[gr][gc-1];
            end
            mwf_cell u_cell (
                .aclk      (aclk),
                .shift_en  (b_adv),
                .pix_in    (feed),
                .term_en   (c_en_reg[gr][gc]),
                .pix_out   (win[gr][gc]),
                .max_term  (cmax[gr][gc]),
                .ones_term (cones[gr][gc])
            );
        end
    end

    // Stage C: reduce each window row and pick the centre.
    logic [PIX_W-1:0] rmax  [NW];
    logic             rones [NW];
    logic [PIX_W-1:0] centre;

    always_comb begin
        centre = PIX_ZERO;
        for (int l = 0; l < NW; l++) begin
            rmax[l]  = PIX_ZERO;
            rones[l] = 1'b1;
            for (int m = 0; m < NW; m++) begin
                if (cmax[l][m] > rmax[l]) begin
                    rmax[l] = cmax[l][m];
                end
                rones[l] = rones[l] && cones[l][m];
                if ((3'(l) == khh) && (3'(m) == kwh)) begin
                    centre = win[l][m];
                end
            end
        end
    end

    // Stage D registers.
    logic             d_valid_reg, d_emit_reg, d_last_reg, d_centre_ok_reg;
    logic [PIX_W-1:0] d_max_reg  [NW];
    logic             d_ones_reg [NW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_emit_reg      <= c_emit_reg;
            d_last_reg      <= c_last_reg;
            d_centre_ok_reg <= (centre == PIX_MAX);
            d_max_reg       <= rmax;
            d_ones_reg      <= rones;
        end
    end

    // Stage D: combine rows into the result pixel.
    logic [PIX_W-1:0] fmax;
    logic             fones;
    out_item_t        res;
    logic             push;

    always_comb begin
        fmax  = PIX_ZERO;
        fones = d_centre_ok_reg;
        for (int l = 0; l < NW; l++) begin
            if (d_max_reg[l] > fmax) begin
                fmax = d_max_reg[l];
            end
            fones = fones && d_ones_reg[l];
        end
        res.pixel_out = mode_reg ? fmax : (fones ? PIX_MAX : PIX_ZERO);
        res.last      = d_last_reg;
    end

    assign push = en && d_valid_reg && d_emit_reg;

    // Output register with a skid register behind it.
    logic      m_valid_reg;
    out_item_t m_data_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_reg : res;
        end else if (push) begin
            skid_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The skid register is only ever filled behind a waiting result.
    `MWF_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> m_valid_reg)
    // A full skid register freezes intake.
    `MWF_ASSERT(a_skid_blocks_in, aclk, aresetn, skid_valid_reg |-> !s_ready)
    // The final result of a frame sends the position counter back to the start.
    `MWF_ASSERT(a_frame_restart, aclk, aresetn,
                (take && emit_a && last_a && !cfg_fire) |=> (pos_reg == '0))
    // Intake pauses in the cycle after a configuration write.
    `MWF_ASSERT(a_cfg_settle, aclk, aresetn, cfg_fire |=> !s_ready)
endmodule
